// ----- hw/rtl/positional_list_engine_macros.svh -----
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define PLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PLE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PLE_ASSERT(name, prop, msg)

`define PLE_ASSERT_IMPL(name, ante, cons, msg)

`define PLE_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/ple_pkg.sv -----
// Shared codes, field widths and control types of the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned FOUND_W = 4;
  localparam int unsigned LEN_W   = 5;

  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_POS  = 3'd4;
  localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd5;
  localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } ple_cmd_t;

  typedef struct packed {
    logic walk_done;
  } ple_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ple_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ple_ctrl.sv -----
// Controller state machine: sequences accept, entry walk and result hand-off.
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ple_sts_t sts_i,
  output ple_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ple_dp.sv -----
// Datapath: element store, length count, entry walk and result registers.
`default_nettype none

module ple_dp
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ple_cmd_t            cmd_i,
  output ple_sts_t                 sts_o,
  input  wire logic [OP_W-1:0]     operation_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [VAL_W-1:0]    value_i,
  output logic      [ST_W-1:0]     status_o,
  output logic      [FOUND_W-1:0]  found_index_o,
  output logic      [LEN_W-1:0]    length_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((POS_W > CW) ? POS_W : CW) + 1;

  typedef enum logic [1:0] {
    WK_NONE,
    WK_INS,
    WK_REM,
    WK_SRCH
  } ple_kind_e;

  logic [CW-1:0]    cnt_q, cnt_d;
  ple_kind_e        kind_q, nx_kind;
  logic [AW-1:0]    at_q, nx_at;
  logic [VAL_W-1:0] val_q;
  logic [ST_W-1:0]  st_q, nx_st;
  logic [AW-1:0]    rd_idx_q, nx_idx;
  logic [CW-1:0]    rd_left_q, nx_left;
  logic             pend_q;
  logic [AW-1:0]    pend_idx_q;
  logic             hit_q;
  logic [AW-1:0]    hit_idx_q;
  logic [ST_W-1:0]  res_status_q;
  logic [FOUND_W-1:0] res_found_q;
  logic [LEN_W-1:0] res_len_q;

  logic [XW-1:0]    cnt_x, pos_x;
  logic             full, empty;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [VAL_W-1:0] rd_data;
  logic             match;

  assign cnt_x = XW'(cnt_q);
  assign pos_x = XW'(position_i);
  assign full  = (cnt_q == CW'(CAPACITY));
  assign empty = (cnt_q == '0);

  always_comb begin
    nx_kind = WK_NONE;
    nx_at   = '0;
    nx_st   = ST_OK;
    case (operation_i) inside
      OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL: begin
        if (full) begin
          nx_st = ST_FULL;
        end else begin
          nx_kind = WK_INS;
          if (operation_i == OP_INS_HEAD) begin
            nx_at = '0;
          end else if (operation_i == OP_INS_TAIL || pos_x > cnt_x) begin
            nx_at = AW'(cnt_q);
          end else begin
            nx_at = AW'(position_i);
          end
        end
      end
      OP_REM_HEAD, OP_REM_POS, OP_REM_TAIL: begin
        if (empty) begin
          nx_st = ST_EMPTY;
        end else if (operation_i == OP_REM_TAIL) begin
          nx_kind = WK_REM;
          nx_at   = AW'(cnt_q - CW'(1));
        end else if (operation_i == OP_REM_HEAD) begin
          nx_kind = WK_REM;
          nx_at   = '0;
        end else if (pos_x >= cnt_x) begin
          nx_st = ST_NOTFOUND;
        end else begin
          nx_kind = WK_REM;
          nx_at   = AW'(position_i);
        end
      end
      OP_SEARCH: begin
        nx_kind = WK_SRCH;
        nx_st   = ST_NOTFOUND;
      end
      default: begin
        nx_st = ST_NOTFOUND;
      end
    endcase
  end

  always_comb begin
    case (nx_kind)
      WK_INS: begin
        nx_left = cnt_q - CW'(nx_at);
        nx_idx  = AW'(cnt_q - CW'(1));
      end
      WK_REM: begin
        nx_left = cnt_q - CW'(1) - CW'(nx_at);
        nx_idx  = nx_at + AW'(1);
      end
      WK_SRCH: begin
        nx_left = cnt_q;
        nx_idx  = '0;
      end
      default: begin
        nx_left = '0;
        nx_idx  = '0;
      end
    endcase
  end

  assign rd_en = cmd_i.step && (rd_left_q != '0);
  assign match = cmd_i.step && pend_q && (kind_q == WK_SRCH) && !hit_q && (rd_data == val_q);
  assign sts_o.walk_done = (rd_left_q == '0) && !pend_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx_q;
    wr_data = rd_data;
    if (cmd_i.finish && kind_q == WK_INS) begin
      wr_en   = 1'b1;
      wr_addr = at_q;
      wr_data = val_q;
    end else if (cmd_i.step && pend_q && kind_q == WK_INS) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx_q + AW'(1);
    end else if (cmd_i.step && pend_q && kind_q == WK_REM) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx_q - AW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.finish && kind_q == WK_INS) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.finish && kind_q == WK_REM) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      kind_q    <= WK_NONE;
      rd_left_q <= '0;
      pend_q    <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.start) begin
        kind_q    <= nx_kind;
        rd_left_q <= nx_left;
        pend_q    <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.step) begin
        pend_q <= rd_en;
        if (rd_en) begin
          rd_left_q <= rd_left_q - CW'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      at_q     <= nx_at;
      val_q    <= value_i;
      st_q     <= nx_st;
      rd_idx_q <= nx_idx;
    end else if (cmd_i.step) begin
      pend_idx_q <= rd_idx_q;
      if (rd_en) begin
        rd_idx_q <= (kind_q == WK_INS) ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
      end
      if (match) begin
        hit_idx_q <= pend_idx_q;
      end
    end
    if (cmd_i.finish) begin
      res_len_q <= LEN_W'(cnt_d);
      if (kind_q == WK_SRCH && hit_q) begin
        res_status_q <= ST_OK;
        res_found_q  <= FOUND_W'(hit_idx_q);
      end else begin
        res_status_q <= st_q;
        res_found_q  <= '0;
      end
    end
  end

  assign status_o      = res_status_q;
  assign found_index_o = res_found_q;
  assign length_o      = res_len_q;

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_engine.sv -----
// Top level of the positional list engine: stream ports, controller and datapath.
`default_nettype none
`include "positional_list_engine_macros.svh"

// Bounded ordered list of up to CAPACITY signed 32-bit elements held in a
// single-port-write, single-port-read RAM. Each item carries one request and
// yields exactly one result item (status, index of a search hit, new length).
// An item walks the entries that it moves or reads: an insert at index
// a moves length-a entries, a remove at index a moves length-a-1 entries,
// and a search reads all length entries. The walk moves one entry per cycle
// through the RAM read and write ports. A new item is taken as soon as the
// previous one is finished, while its result may still wait in the output
// register. The RAM is not cleared.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [2:0] operation, [7:3] position, [39:8] value
  input  wire logic [39:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [5:2] found_index, [10:6] length, [15:11] zero
  output logic      [15:0] m_axis_tdata_o
);

  ple_cmd_t           cmd;
  ple_sts_t           sts;
  logic [ST_W-1:0]    status;
  logic [FOUND_W-1:0] found_index;
  logic [LEN_W-1:0]   length;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ple_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (s_axis_tdata_i[2:0]),
    .position_i    (s_axis_tdata_i[7:3]),
    .value_i       (s_axis_tdata_i[39:8]),
    .status_o      (status),
    .found_index_o (found_index),
    .length_o      (length)
  );

  assign m_axis_tdata_o = {5'b0, length, found_index, status};

  `PLE_ASSERT(a_cmd_onehot, $onehot0({cmd.start, cmd.step, cmd.finish}), "overlapping commands")
  `PLE_ASSERT_IMPL(a_no_overwrite, cmd.finish, !m_axis_tvalid_o || m_axis_tready_i, "result overwritten")
  `PLE_ASSERT_NEXT(a_finish_valid, cmd.finish, m_axis_tvalid_o, "result not presented")
  `PLE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "accepted while busy")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the positional list engine.
`timescale 1ns / 1ps

module tb;
  import ple_pkg::*;

  localparam int unsigned LIST_CAP = 16;
  localparam int unsigned WALK_CYCLES = LIST_CAP + 4;
  // bound for the slowest run: about 2030 items, each with its walk, input gap and output stall
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef enum int unsigned {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} op_bias_e;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [FOUND_W-1:0] found_index;
    logic [ST_W-1:0]    status;
  } list_result_t;

  logic        clk_i;
  logic        rst_n;
  logic        s_valid;
  logic [39:0] s_data;
  logic        m_ready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  logic [VAL_W-1:0] list_mem [LIST_CAP];
  int unsigned      list_len;
  int unsigned      deepest_len;
  list_result_t     pending_results[$];
  int unsigned      mismatch_count;
  int unsigned      requests_sent;
  int unsigned      results_checked;
  int unsigned      status_seen [4];
  int unsigned      cycle_count;
  bit               no_idle;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic int unsigned draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
    list_result_t res;
    int unsigned  at;
    int unsigned  i;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_INS_HEAD, OP_INS_POS, OP_INS_TAIL: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_INS_HEAD) at = 0;
          else if (op == OP_INS_TAIL || pos > list_len) at = list_len;
          else at = pos;
          for (i = list_len; i > at; i--) list_mem[i] = list_mem[i - 1];
          list_mem[at] = val;
          list_len++;
        end
      end
      OP_REM_HEAD, OP_REM_POS, OP_REM_TAIL: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_REM_TAIL) begin
          list_len--;
        end else begin
          at = (op == OP_REM_HEAD) ? 0 : pos;
          if (at >= list_len) begin
            res.status = ST_NOTFOUND;
          end else begin
            for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
          end
        end
      end
      OP_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            res.status = ST_OK;
            res.found_index = i[FOUND_W-1:0];
            break;
          end
        end
      end
      default: begin
        res.status = ST_NOTFOUND;
      end
    endcase
    res.length = list_len[LEN_W-1:0];
    if (list_len > deepest_len) deepest_len = list_len;
    pending_results.push_back(res);
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {val, pos, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_list_op(op, pos, val);
    requests_sent++;
  endtask

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      got = m_axis_tdata_o[10:0];
      status_seen[got.status]++;
      results_checked++;
      if (m_axis_tdata_o[15:11] != '0) begin
        report_mismatch($sformatf("padding bits %h not zero", m_axis_tdata_o[15:11]));
      end
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", got));
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        end
        if (got.found_index != want.found_index) begin
          report_mismatch($sformatf("found_index %0d, want %0d",
                                    got.found_index, want.found_index));
        end
        if (got.length != want.length) begin
          report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("positional_list_engine regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return VAL_W'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_position();
    if ($urandom_range(0, 4) == 0 || list_len == 0) begin
      return POS_W'($urandom_range(0, LIST_CAP));
    end
    return POS_W'($urandom_range(0, list_len));
  endfunction

  function automatic logic [OP_W-1:0] random_op(input op_bias_e bias);
    int unsigned roll;
    int unsigned ins_share;
    int unsigned rem_share;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin ins_share = 55; rem_share = 25; end
      BIAS_DRAIN: begin ins_share = 25; rem_share = 45; end
      default:    begin ins_share = 40; rem_share = 35; end
    endcase
    if (roll < ins_share) begin
      case ($urandom_range(0, 2))
        0: return OP_INS_HEAD;
        1: return OP_INS_POS;
        default: return OP_INS_TAIL;
      endcase
    end
    if (roll < ins_share + rem_share) begin
      case ($urandom_range(0, 2))
        0: return OP_REM_HEAD;
        1: return OP_REM_POS;
        default: return OP_REM_TAIL;
      endcase
    end
    return OP_SEARCH;
  endfunction

  task automatic test_empty_list();
    send_request(OP_REM_HEAD, '0, '0);
    send_request(OP_REM_POS, '0, '0);
    send_request(OP_REM_TAIL, 5'd16, 32'hffff_ffff);
    send_request(OP_SEARCH, '0, '0);
    send_request(OP_UNUSED, 5'd16, 32'h8000_0000);
  endtask

  task automatic test_fill_and_overflow();
    send_request(OP_INS_HEAD, '0, 32'h8000_0000);
    send_request(OP_INS_TAIL, '0, 32'h7fff_ffff);
    send_request(OP_INS_POS, 5'd16, 32'h0000_0000);
    send_request(OP_INS_POS, '0, 32'hffff_ffff);
    send_request(OP_INS_POS, 5'd2, 32'h0000_0001);
    send_request(OP_INS_HEAD, '0, 32'h1234_5678);
    send_request(OP_INS_POS, 5'd15, 32'hdead_beef);
    for (int unsigned k = 7; k < LIST_CAP; k++) begin
      send_request(OP_INS_TAIL, '0, 32'h0000_0005);
    end
    send_request(OP_INS_HEAD, '0, 32'h5555_5555);
    send_request(OP_INS_POS, 5'd3, 32'haaaa_aaaa);
    send_request(OP_INS_TAIL, '0, 32'h0f0f_0f0f);
  endtask

  task automatic test_full_list_access();
    send_request(OP_SEARCH, '0, 32'h0000_0005);
    send_request(OP_SEARCH, '0, list_mem[LIST_CAP - 1]);
    send_request(OP_REM_POS, 5'd16, '0);
    send_request(OP_REM_POS, 5'd15, '0);
    send_request(OP_REM_HEAD, '0, '0);
    send_request(OP_REM_TAIL, '0, '0);
    send_request(OP_SEARCH, 5'd31, 32'h0f0f_0f0f);
  endtask

  task automatic test_random_ops();
    op_bias_e         bias;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        bias = op_bias_e'($urandom_range(0, 2));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      op = random_op(bias);
      if (op == OP_SEARCH && list_len > 0 && $urandom_range(0, 2) != 0) begin
        val = list_mem[$urandom_range(0, list_len - 1)];
      end else begin
        val = random_value();
      end
      send_request(op, random_position(), val);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    s_valid        <= 1'b0;
    s_data         <= '0;
    m_ready        <= 1'b0;
    list_len       = 0;
    deepest_len    = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    results_checked = 0;
    no_idle        = 1'b0;
    foreach (status_seen[k]) status_seen[k] = 0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_fill_and_overflow();
    test_full_list_access();
    test_random_ops();

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * WALK_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("covered %0d requests, %0d results checked, deepest list %0d of %0d",
             requests_sent, results_checked, deepest_len, LIST_CAP);
    $display("statuses seen: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], mismatch_count);
    if (mismatch_count == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

endmodule
